@@ rtl/core/itd_pkg.sv @@
// ----------------------------------------------------------------------------
// itd_pkg
// Shared constants, codes and control structs of the interval timer tone
// divider.
// ----------------------------------------------------------------------------
package itd_pkg;

  localparam int unsigned NumCh    = 3;
  localparam int unsigned OffsetW  = 2;
  localparam int unsigned DataW    = 8;
  localparam int unsigned ChW      = 2;
  localparam int unsigned CountW   = 16;
  localparam int unsigned FreqW    = 24;
  localparam int unsigned DivSteps = FreqW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  localparam logic [FreqW-1:0] InputClockHz = 24'd14318184;

  // Register offsets
  localparam logic [OffsetW-1:0] OFFSET_CONTROL = 2'd3;

  // Channel select code that addresses no counter
  localparam logic [ChW-1:0] CH_NONE = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the input beat
    logic step;   // one restoring division step
  } itd_cmd_t;

  // Datapath to controller, valid with the input beat
  typedef struct packed {
    logic emit;   // the beat produces a result
    logic zero;   // count is zero, no division needed
  } itd_status_t;

endpackage

@@ rtl/core/itd_if.sv @@
// ----------------------------------------------------------------------------
// itd_if
// Valid/ready channels for bus write beats and tone result beats.
// ----------------------------------------------------------------------------
interface itd_in_if import itd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OffsetW-1:0] register_offset;
  logic [DataW-1:0]   write_data;

  modport source (output valid, register_offset, write_data, input ready);
  modport sink   (input valid, register_offset, write_data, output ready);
endinterface

interface itd_out_if import itd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChW-1:0]   channel_index;
  logic [FreqW-1:0] tone_frequency;
  logic             voice_on;

  modport source (output valid, channel_index, tone_frequency, voice_on, input ready);
  modport sink   (input valid, channel_index, tone_frequency, voice_on, output ready);
endinterface

@@ rtl/core/itd_ctrl.sv @@
// ----------------------------------------------------------------------------
// itd_ctrl
// Sequencer: accept a beat, run the divider, hold the result until taken.
// ----------------------------------------------------------------------------
module itd_ctrl import itd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  itd_status_t status_i,
  output itd_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDivide = 2'd1;
  localparam logic [1:0] StOutput = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOutput);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          if (status_i.emit) begin
            state_d = status_i.zero ? StOutput : StDivide;
          end
        end
      end
      StDivide: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + StepW'(1);
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = StOutput;
        end
      end
      StOutput: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

@@ rtl/core/itd_dp.sv @@
// ----------------------------------------------------------------------------
// itd_dp
// Counter registers, byte toggles and a restoring divider that yields one
// quotient bit per step.
// ----------------------------------------------------------------------------
module itd_dp import itd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [OffsetW-1:0] register_offset_i,
  input  logic [DataW-1:0]   write_data_i,
  input  itd_cmd_t           cmd_i,
  output itd_status_t        status_o,
  output logic [ChW-1:0]     channel_index_o,
  output logic [FreqW-1:0]   tone_frequency_o,
  output logic               voice_on_o
);

  logic [CountW-1:0] count_q [NumCh];
  logic [NumCh-1:0]  high_next_q;

  logic [CountW-1:0] div_q;
  logic [CountW-1:0] rem_q;
  logic [FreqW-1:0]  quo_q;
  logic [ChW-1:0]    ch_q;
  logic              voice_q;

  logic              is_ctrl;
  logic [ChW-1:0]    ch_sel;
  logic [CountW-1:0] cur_count;
  logic [CountW-1:0] new_count;
  logic              high_write;

  logic [CountW:0]   rem_shift;
  logic              fits;

  // Decode the beat
  assign is_ctrl    = (register_offset_i == OFFSET_CONTROL);
  assign ch_sel     = is_ctrl ? write_data_i[7:6] : register_offset_i;
  assign cur_count  = (ch_sel == CH_NONE) ? '0 : count_q[ch_sel[ChW-1:0]];
  assign high_write = !is_ctrl && (ch_sel != CH_NONE) && high_next_q[ch_sel];
  assign new_count  = is_ctrl ? cur_count : {write_data_i, cur_count[DataW-1:0]};

  assign status_o.emit = is_ctrl ? (ch_sel != CH_NONE) : high_write;
  assign status_o.zero = (new_count == '0);

  // Restoring step: shift in the next dividend bit, subtract when it fits
  assign rem_shift = {rem_q, quo_q[FreqW-1]};
  assign fits      = (rem_shift >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        count_q[i] <= '0;
      end
      high_next_q <= '0;
    end else if (cmd_i.load && !is_ctrl && (ch_sel != CH_NONE)) begin
      if (high_next_q[ch_sel]) begin
        count_q[ch_sel] <= new_count;
      end else begin
        count_q[ch_sel] <= {cur_count[CountW-1:DataW], write_data_i};
      end
      high_next_q[ch_sel] <= !high_next_q[ch_sel];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      div_q   <= new_count;
      rem_q   <= '0;
      quo_q   <= status_o.zero ? '0 : InputClockHz;
      ch_q    <= ch_sel;
      voice_q <= is_ctrl ? (|write_data_i[3:1]) : 1'b1;
    end else if (cmd_i.step) begin
      rem_q <= fits ? CountW'(rem_shift - {1'b0, div_q}) : rem_shift[CountW-1:0];
      quo_q <= {quo_q[FreqW-2:0], fits};
    end
  end

  assign channel_index_o  = ch_q;
  assign tone_frequency_o = quo_q;
  assign voice_on_o       = voice_q;

endmodule

@@ rtl/core/interval_timer_tone_divider_core.sv @@
// ----------------------------------------------------------------------------
// interval_timer_tone_divider_core
// Three-counter interval timer front end that turns bus writes into tone
// channel settings.
// ----------------------------------------------------------------------------
// Each write beat is a register offset and a byte. Offsets 0 to 2 load the
// matching 16-bit count, low byte first and then high byte, tracked by a
// toggle per counter; the high byte emits one result beat for that channel
// with the voice on. Offset 3 is a control word: bits 7:6 pick the channel,
// whose current frequency is emitted with the voice on unless bits 3:1 are
// all zero; channel select 3 is dropped without effect. The frequency is
// 14318184 divided by the count, floored, and zero for a zero count. A low
// byte or a dropped control word is accepted with no result and leaves the
// core idle. A beat that yields a result is accepted, runs the restoring
// divider (one quotient bit per cycle) unless the count is zero, and then
// waits in the output register until the sink takes it; no write is
// accepted meanwhile, and the next one is accepted in the cycle after that.
// ----------------------------------------------------------------------------
module interval_timer_tone_divider_core import itd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  itd_in_if.sink    in_i,
  itd_out_if.source out_o
);

  itd_cmd_t    cmd;
  itd_status_t status;

  // Sequence the beat: accept, divide, hold the result
  itd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the counts and run the divider
  itd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .register_offset_i (in_i.register_offset),
    .write_data_i      (in_i.write_data),
    .cmd_i             (cmd),
    .status_o          (status),
    .channel_index_o   (out_o.channel_index),
    .tone_frequency_o  (out_o.tone_frequency),
    .voice_on_o        (out_o.voice_on)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the interval timer tone divider core. Drives bus
// write beats in random bursts, stalls the result side on its own pattern,
// and checks each result beat against directed rows or an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
  import itd_pkg::*;

  // Counter data offsets and channel numbers
  localparam logic [OffsetW-1:0] OFF_CNT0 = 2'd0;
  localparam logic [OffsetW-1:0] OFF_CNT1 = 2'd1;
  localparam logic [OffsetW-1:0] OFF_CNT2 = 2'd2;
  localparam logic [ChW-1:0]     CH_0     = 2'd0;
  localparam logic [ChW-1:0]     CH_1     = 2'd1;
  localparam logic [ChW-1:0]     CH_2     = 2'd2;

  localparam int unsigned RandomWrites = 700;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned CycleLimit   = 1000000;

  typedef struct packed {
    logic [ChW-1:0]   ch;
    logic [FreqW-1:0] freq;
    logic             voice;
  } tone_beat_t;

  typedef struct packed {
    logic [OffsetW-1:0] offset;
    logic [DataW-1:0]   data;
    bit                 typed;
    tone_beat_t         beat;
  } write_row_t;

  logic clk = 1'b0;
  logic rst_n;

  itd_in_if  in_bus ();
  itd_out_if out_bus ();

  interval_timer_tone_divider_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Counter model state
  logic [CountW-1:0] count_q   [NumCh];
  bit                hi_next_q [NumCh];

  tone_beat_t   tone_expect_q [$];
  write_row_t   directed_rows [$];
  tone_beat_t   row_beat;
  bit           row_typed;
  bit           hold_pending;
  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;
  int unsigned  burst_left;

  function automatic logic [FreqW-1:0] tone_of_count(logic [CountW-1:0] c);
    if (c == '0) return '0;
    return InputClockHz / FreqW'(c);
  endfunction

  // Apply one write to the counter model; return whether it yields a beat.
  function automatic bit tone_model_step(input logic [OffsetW-1:0] off,
                                         input logic [DataW-1:0] dat,
                                         output tone_beat_t beat);
    logic [ChW-1:0] sel;
    beat = '0;
    if (off == OFFSET_CONTROL) begin
      sel = dat[7:6];
      if (sel == CH_NONE) return 1'b0;
      beat.ch    = sel;
      beat.freq  = tone_of_count(count_q[sel]);
      beat.voice = |dat[3:1];
      return 1'b1;
    end
    if (!hi_next_q[off]) begin
      hi_next_q[off]     = 1'b1;
      count_q[off][7:0]  = dat;
      return 1'b0;
    end
    hi_next_q[off]     = 1'b0;
    count_q[off][15:8] = dat;
    beat.ch    = off;
    beat.freq  = tone_of_count(count_q[off]);
    beat.voice = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [DataW-1:0] ctrl_word(logic [ChW-1:0] ch, logic [2:0] mode);
    return {ch, 2'b00, mode, 1'b0};
  endfunction

  function automatic tone_beat_t mk_beat(logic [ChW-1:0] ch, logic [FreqW-1:0] freq,
                                         logic voice);
    tone_beat_t b;
    b.ch    = ch;
    b.freq  = freq;
    b.voice = voice;
    return b;
  endfunction

  task automatic add_row(input logic [OffsetW-1:0] off, input logic [DataW-1:0] dat,
                         input bit typed, input tone_beat_t beat);
    write_row_t r;
    r.offset = off;
    r.data   = dat;
    r.typed  = typed;
    r.beat   = beat;
    directed_rows.push_back(r);
  endtask

  // Offer one beat until taken, then close out the burst with a gap if due.
  task automatic drive_write(input logic [OffsetW-1:0] off, input logic [DataW-1:0] dat,
                             input bit typed, input tone_beat_t beat);
    int unsigned gap;
    in_bus.valid           <= 1'b1;
    in_bus.register_offset <= off;
    in_bus.write_data      <= dat;
    row_typed              <= typed;
    row_beat               <= beat;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_bus.valid           <= 1'b0;
        in_bus.register_offset <= OffsetW'($urandom);
        in_bus.write_data      <= DataW'($urandom);
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 15) == 0) ? 60 : $urandom_range(1, 12);
    end
  endtask

  // Predict on accepted writes, check on accepted results.
  always @(posedge clk) begin
    tone_beat_t pred;
    tone_beat_t want;
    bit         emits;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        emits = tone_model_step(in_bus.register_offset, in_bus.write_data, pred);
        if (row_typed) tone_expect_q.push_back(row_beat);
        else if (emits) tone_expect_q.push_back(pred);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (tone_expect_q.size() == 0) begin
          $error("unexpected result beat: channel_index %0d tone_frequency %0d voice_on %0d",
                 out_bus.channel_index, out_bus.tone_frequency, out_bus.voice_on);
          mismatch_cnt++;
        end else begin
          want = tone_expect_q.pop_front();
          if (out_bus.channel_index !== want.ch) begin
            $error("channel_index mismatch: expected %0d, actual %0d",
                   want.ch, out_bus.channel_index);
            mismatch_cnt++;
          end
          if (out_bus.tone_frequency !== want.freq) begin
            $error("tone_frequency mismatch: expected %0d, actual %0d",
                   want.freq, out_bus.tone_frequency);
            mismatch_cnt++;
          end
          if (out_bus.voice_on !== want.voice) begin
            $error("voice_on mismatch: expected %0d, actual %0d",
                   want.voice, out_bus.voice_on);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $error("timeout after %0d cycles, %0d beats outstanding",
             cycle_cnt, tone_expect_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: stall patterns of random span, and one long hold once the
  // random part has started.
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    out_bus.ready = 1'b0;
    tick = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= (tick % 3 == 0);
        endcase
        tick++;
        @(negedge clk);
      end
    end
  end

  initial begin : write_source
    int unsigned       writes_done;
    int unsigned       pick;
    logic [ChW-1:0]    ch;
    logic [CountW-1:0] cnt;
    logic [DataW-1:0]  dat;
    tone_beat_t        none;

    none = '0;
    in_bus.valid           = 1'b0;
    in_bus.register_offset = '0;
    in_bus.write_data      = '0;
    row_typed              = 1'b0;
    row_beat               = '0;
    hold_pending           = 1'b0;
    mismatch_cnt           = 0;
    cycle_cnt              = 0;
    burst_left             = $urandom_range(1, 12);
    for (int k = 0; k < NumCh; k++) begin
      count_q[k]   = '0;
      hi_next_q[k] = 1'b0;
    end

    // Directed rows: reset values, count extremes, mode bits, ignored select,
    // a control word between the two bytes of a load.
    add_row(OFFSET_CONTROL, ctrl_word(CH_0, 3'b111), 1, mk_beat(CH_0, 0, 1));
    add_row(OFFSET_CONTROL, ctrl_word(CH_1, 3'b000), 1, mk_beat(CH_1, 0, 0));
    add_row(OFFSET_CONTROL, ctrl_word(CH_NONE, 3'b111), 0, none);
    add_row(OFF_CNT0, 8'h01, 0, none);
    add_row(OFF_CNT0, 8'h00, 1, mk_beat(CH_0, InputClockHz, 1));
    add_row(OFF_CNT1, 8'hFF, 0, none);
    add_row(OFF_CNT1, 8'hFF, 1, mk_beat(CH_1, 218, 1));
    add_row(OFF_CNT2, 8'h00, 0, none);
    add_row(OFF_CNT2, 8'h00, 1, mk_beat(CH_2, 0, 1));
    add_row(OFFSET_CONTROL, ctrl_word(CH_2, 3'b001), 1, mk_beat(CH_2, 0, 1));
    add_row(OFFSET_CONTROL, ctrl_word(CH_1, 3'b010), 1, mk_beat(CH_1, 218, 1));
    add_row(OFFSET_CONTROL, ctrl_word(CH_0, 3'b100), 1, mk_beat(CH_0, InputClockHz, 1));
    add_row(OFFSET_CONTROL, 8'h31, 1, mk_beat(CH_0, InputClockHz, 0));
    add_row(OFFSET_CONTROL, 8'hFF, 0, none);
    add_row(OFF_CNT2, 8'h00, 0, none);
    add_row(OFF_CNT2, 8'h01, 1, mk_beat(CH_2, 55930, 1));
    add_row(OFF_CNT0, 8'hAB, 0, none);
    add_row(OFFSET_CONTROL, ctrl_word(CH_0, 3'b011), 0, none);
    add_row(OFF_CNT0, 8'h80, 0, none);
    add_row(OFF_CNT1, 8'h00, 0, none);
    add_row(OFF_CNT1, 8'h80, 0, none);
    add_row(OFFSET_CONTROL, 8'h71, 0, none);

    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      drive_write(directed_rows[i].offset, directed_rows[i].data,
                  directed_rows[i].typed, directed_rows[i].beat);

    // Random part: mostly whole two-byte loads and control words, with
    // stray single bytes that knock a counter's byte order out of step.
    hold_pending = 1'b1;
    writes_done  = 0;
    while (writes_done < RandomWrites) begin
      pick = $urandom_range(0, 99);
      ch   = ChW'($urandom_range(0, 2));
      if (pick < 55) begin
        case ($urandom_range(0, 9))
          0:       cnt = '0;
          1:       cnt = CountW'($urandom_range(1, 3));
          2:       cnt = '1;
          3:       cnt = {1'b1, 15'($urandom)};
          4:       cnt = CountW'($urandom_range(1, 255));
          default: cnt = CountW'($urandom);
        endcase
        drive_write(ch, cnt[7:0], 0, none);
        drive_write(ch, cnt[15:8], 0, none);
        writes_done += 2;
      end else if (pick < 88) begin
        dat = DataW'($urandom);
        if ($urandom_range(0, 7) == 0) dat[7:6] = CH_NONE;
        else dat[7:6] = ch;
        if ($urandom_range(0, 3) == 0) dat[3:1] = 3'b000;
        drive_write(OFFSET_CONTROL, dat, 0, none);
        if (dat[7:6] != CH_NONE) writes_done++;
      end else begin
        drive_write(ch, DataW'($urandom), 0, none);
        writes_done++;
      end
    end

    in_bus.valid <= 1'b0;
    while (tone_expect_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_cnt == 0 && tone_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
